/* rtl/sha1_message_digest_unit_macros.svh */
// ----------------------------------------------------------------------------
// sha1 message digest unit - assertion macros
// concurrent checks on the sequencer and the round unit, off for synthesis
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SHA1MD_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("sha1md: same-cycle check failed");
// next-cycle implication
`define SHA1MD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sha1md: next-cycle check failed");
`else
`define SHA1MD_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define SHA1MD_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* rtl/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types, constants and round functions of the sha1 digest unit
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

   // five 32-bit words, word 0 in the lowest bits
   typedef logic [4:0][31:0] sha1md_words_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTES,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMPRESS,
      ST_OUTPUT
   } sha1md_state_type;

   typedef enum logic [1:0] {
      RU_IDLE,
      RU_ROUND,
      RU_ADD
   } sha1md_ru_state_type;

   typedef struct packed {
      logic push;
      logic start;
      logic init;
   } sha1md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sha1md_status_type;

   localparam sha1md_words_type IV = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] K_PHASE0 = 32'h5A827999;
   localparam logic [31:0] K_PHASE1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_PHASE2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_PHASE3 = 32'hCA62C1D6;

   localparam logic [6:0] PHASE1_ROUND = 7'd20;
   localparam logic [6:0] PHASE2_ROUND = 7'd40;
   localparam logic [6:0] PHASE3_ROUND = 7'd60;
   localparam logic [6:0] LAST_ROUND   = 7'd79;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_START_POS = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [5:0] LAST_WORD_POS = 6'd60;
   localparam logic [2:0] WORD_BYTES    = 3'd4;
   localparam logic [2:0] LEN_LAST_IDX  = 3'd7;

   function automatic logic [31:0] sha1md_f(input logic [6:0] round,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      logic [31:0] f;
      if (round < PHASE1_ROUND) begin
         f = d ^ (b & (c ^ d));
      end else if (round < PHASE2_ROUND) begin
         f = b ^ c ^ d;
      end else if (round < PHASE3_ROUND) begin
         f = (b & c) | (d & (b | c));
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [31:0] sha1md_k(input logic [6:0] round);
      logic [31:0] k;
      if (round < PHASE1_ROUND) begin
         k = K_PHASE0;
      end else if (round < PHASE2_ROUND) begin
         k = K_PHASE1;
      end else if (round < PHASE3_ROUND) begin
         k = K_PHASE2;
      end else begin
         k = K_PHASE3;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

/* rtl/sha1md_round.sv */
// ----------------------------------------------------------------------------
// sha1md_round
// chaining words, 16-word schedule window and one sha1 round per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_round (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sha1md_pkg::sha1md_ctrl_type  ctrl,
   input  wire logic [31:0]                  push_word,
   output sha1md_pkg::sha1md_status_type     status,
   output sha1md_pkg::sha1md_words_type      digest
);

   sha1md_pkg::sha1md_ru_state_type state_ff, state_in;
   logic [6:0]                      round_ff, round_in;
   logic [31:0]                     a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]                     a_in, b_in, c_in, d_in, e_in;
   logic [31:0]                     w_ff [16];
   logic [31:0]                     w_in [16];
   sha1md_pkg::sha1md_words_type    h_ff, h_in;
   logic [31:0]                     round_sum;
   logic [31:0]                     sched_mix;

   assign round_sum = {a_ff[26:0], a_ff[31:27]}
                    + sha1md_pkg::sha1md_f(round_ff, b_ff, c_ff, d_ff)
                    + e_ff + sha1md_pkg::sha1md_k(round_ff) + w_ff[0];
   assign sched_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   assign status.busy = (state_ff != sha1md_pkg::RU_IDLE);
   assign status.done = (state_ff == sha1md_pkg::RU_ADD);
   assign digest      = h_ff;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      h_in     = h_ff;
      w_in     = w_ff;
      unique case (state_ff)
         sha1md_pkg::RU_IDLE: begin
            if (ctrl.push) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               w_in[15] = push_word;
            end
            if (ctrl.init) begin
               h_in = sha1md_pkg::IV;
            end
            if (ctrl.start) begin
               a_in     = h_ff[0];
               b_in     = h_ff[1];
               c_in     = h_ff[2];
               d_in     = h_ff[3];
               e_in     = h_ff[4];
               round_in = '0;
               state_in = sha1md_pkg::RU_ROUND;
            end
         end
         sha1md_pkg::RU_ROUND: begin
            a_in = round_sum;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            // window slides by one, next schedule word enters at the top
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = {sched_mix[30:0], sched_mix[31]};
            round_in = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               state_in = sha1md_pkg::RU_ADD;
            end
         end
         sha1md_pkg::RU_ADD: begin
            h_in[0]  = h_ff[0] + a_ff;
            h_in[1]  = h_ff[1] + b_ff;
            h_in[2]  = h_ff[2] + c_ff;
            h_in[3]  = h_ff[3] + d_ff;
            h_in[4]  = h_ff[4] + e_ff;
            state_in = sha1md_pkg::RU_IDLE;
         end
         default: begin
            state_in = sha1md_pkg::RU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::RU_IDLE;
         round_ff <= '0;
         h_ff     <= sha1md_pkg::IV;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      w_ff <= w_in;
   end

endmodule

`default_nettype wire

/* rtl/sha1_message_digest_unit.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// sha1 over a byte message fed as big-endian words, one digest per message
// ----------------------------------------------------------------------------
// A word with four bytes that lands on a word boundary of the current 64-byte
// block is pushed whole as it is accepted; any other word is packed one byte
// per cycle after its accept cycle, while no block compression holds it. Each
// full block runs through a single shared round unit, one round per cycle: the
// sequencer stalls for the 80 rounds and the chaining add of each block, and
// takes no new word until they are done. The final word is followed by
// byte-serial padding and one or two block compressions before the digest
// appears on the result side; the next message may be accepted while that
// digest still waits to be taken. No clearing pass is needed after reset.
`default_nettype none

`include "sha1_message_digest_unit_macros.svh"

module sha1_message_digest_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] message_word, [34:32] byte_count_valid, [39:35] zero
   input  wire logic [39:0]  req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] digest_h0, [63:32] digest_h1, [95:64] digest_h2,
   // [127:96] digest_h3, [159:128] digest_h4
   output logic [159:0]      rsp_tdata
);

   sha1md_pkg::sha1md_state_type  state_ff, state_in;
   sha1md_pkg::sha1md_state_type  ret_ff, ret_in;
   sha1md_pkg::sha1md_state_type  after_put;
   logic [5:0]                    pos_ff, pos_in;
   logic [60:0]                   msg_ff, msg_in;
   logic [2:0]                    idx_ff, idx_in;
   logic [2:0]                    count_ff, count_in;
   logic                          last_ff, last_in;
   logic [31:0]                   word_ff, word_in;
   logic [23:0]                   partial_ff, partial_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sha1md_pkg::sha1md_words_type  digest_ff, digest_in;

   sha1md_pkg::sha1md_ctrl_type   ru_ctrl;
   sha1md_pkg::sha1md_status_type ru_status;
   sha1md_pkg::sha1md_words_type  ru_digest;
   logic [31:0]                   push_word;

   logic [31:0]                   req_word;
   logic [2:0]                    req_count;
   logic [2:0]                    req_clamped;
   logic [63:0]                   len_bits;
   logic                          put_valid;
   logic [7:0]                    put_data;

   assign req_word    = req_tdata[31:0];
   assign req_count   = req_tdata[34:32];
   assign req_clamped = (req_count > sha1md_pkg::WORD_BYTES) ? sha1md_pkg::WORD_BYTES
                                                             : req_count;
   assign len_bits    = {msg_ff, 3'b000};

   assign req_tready  = (state_ff == sha1md_pkg::ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = digest_ff;

   sha1md_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ru_ctrl),
      .push_word (push_word),
      .status    (ru_status),
      .digest    (ru_digest)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      msg_in       = msg_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      partial_in   = partial_ff;
      rsp_valid_in = rsp_valid_ff;
      digest_in    = digest_ff;
      ru_ctrl      = '0;
      push_word    = '0;
      put_valid    = 1'b0;
      put_data     = 8'h00;
      after_put    = state_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               last_in  = req_tlast;
               word_in  = req_word;
               count_in = req_clamped;
               idx_in   = '0;
               after_put = req_tlast ? sha1md_pkg::ST_PAD_MARK : sha1md_pkg::ST_IDLE;
               if ((req_clamped == sha1md_pkg::WORD_BYTES) && (pos_ff[1:0] == 2'b00)) begin
                  // aligned full word goes straight into the window
                  ru_ctrl.push = 1'b1;
                  push_word    = req_word;
                  pos_in       = pos_ff + 6'd4;
                  msg_in       = msg_ff + 61'd4;
                  if (pos_ff == sha1md_pkg::LAST_WORD_POS) begin
                     ru_ctrl.start = 1'b1;
                     ret_in        = after_put;
                     state_in      = sha1md_pkg::ST_COMPRESS;
                  end else begin
                     state_in = after_put;
                  end
               end else if (req_clamped == 3'd0) begin
                  state_in = after_put;
               end else begin
                  state_in = sha1md_pkg::ST_BYTES;
               end
            end
         end
         sha1md_pkg::ST_BYTES: begin
            put_valid = 1'b1;
            put_data  = word_ff[{~idx_ff[1:0], 3'b000} +: 8];
            msg_in    = msg_ff + 61'd1;
            idx_in    = idx_ff + 3'd1;
            if ((idx_ff + 3'd1) == count_ff) begin
               after_put = last_ff ? sha1md_pkg::ST_PAD_MARK : sha1md_pkg::ST_IDLE;
            end else begin
               after_put = sha1md_pkg::ST_BYTES;
            end
         end
         sha1md_pkg::ST_PAD_MARK: begin
            put_valid = 1'b1;
            put_data  = sha1md_pkg::PAD_MARK_BYTE;
            idx_in    = '0;
            after_put = ((pos_ff + 6'd1) == sha1md_pkg::LEN_START_POS) ? sha1md_pkg::ST_PAD_LEN
                                                                       : sha1md_pkg::ST_PAD_ZERO;
         end
         sha1md_pkg::ST_PAD_ZERO: begin
            put_valid = 1'b1;
            put_data  = 8'h00;
            idx_in    = '0;
            after_put = ((pos_ff + 6'd1) == sha1md_pkg::LEN_START_POS) ? sha1md_pkg::ST_PAD_LEN
                                                                       : sha1md_pkg::ST_PAD_ZERO;
         end
         sha1md_pkg::ST_PAD_LEN: begin
            // bit length, most significant byte first
            put_valid = 1'b1;
            put_data  = len_bits[{~idx_ff, 3'b000} +: 8];
            idx_in    = idx_ff + 3'd1;
            after_put = (idx_ff == sha1md_pkg::LEN_LAST_IDX) ? sha1md_pkg::ST_OUTPUT
                                                             : sha1md_pkg::ST_PAD_LEN;
         end
         sha1md_pkg::ST_COMPRESS: begin
            if (ru_status.done) begin
               state_in = ret_ff;
            end
         end
         sha1md_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               digest_in    = ru_digest;
               ru_ctrl.init = 1'b1;
               msg_in       = '0;
               pos_in       = '0;
               state_in     = sha1md_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      // byte-wise packing into the current block
      if (put_valid) begin
         partial_in = {partial_ff[15:0], put_data};
         pos_in     = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'b11) begin
            ru_ctrl.push = 1'b1;
            push_word    = {partial_ff, put_data};
         end
         if (pos_ff == sha1md_pkg::LAST_POS) begin
            ru_ctrl.start = 1'b1;
            ret_in        = after_put;
            state_in      = sha1md_pkg::ST_COMPRESS;
         end else begin
            state_in = after_put;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::ST_IDLE;
         ret_ff       <= sha1md_pkg::ST_IDLE;
         pos_ff       <= '0;
         msg_ff       <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         msg_ff       <= msg_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      partial_ff <= partial_in;
      digest_ff  <= digest_in;
   end

   `SHA1MD_ASSERT_IMPLY(a_ready_round_idle, clock, reset, req_tready, !ru_status.busy)
   `SHA1MD_ASSERT_IMPLY(a_output_block_aligned, clock, reset,
                        state_ff == sha1md_pkg::ST_OUTPUT, pos_ff == 6'd0)
   `SHA1MD_ASSERT_IMPLY(a_start_when_idle, clock, reset, ru_ctrl.start, !ru_status.busy)
   `SHA1MD_ASSERT_NEXT(a_start_runs, clock, reset, ru_ctrl.start, ru_status.busy)

endmodule

`default_nettype wire
